// ===== design/u8u2_pkg.sv =====
`timescale 1ns / 1ps

package u8u2_pkg;

    // Queue between the classifier and the unit sequencer
    localparam int QUEUE_DEPTH_DEF = 4;

    // Console code units
    localparam logic [15:0] UNIT_REPL = 16'h003F;
    localparam logic [15:0] UNIT_CR   = 16'h000D;
    localparam logic [15:0] UNIT_LF   = 16'h000A;

    // Byte classification limits
    localparam logic [7:0] BYTE_CONT_MASK = 8'hC0;
    localparam logic [7:0] BYTE_CONT_TAG  = 8'h80;
    localparam logic [7:0] BYTE_LEAD_LO   = 8'hC2;
    localparam logic [7:0] BYTE_LEAD_HI   = 8'hF4;
    localparam logic [7:0] BYTE_LEAD_3    = 8'hE0;
    localparam logic [7:0] BYTE_LEAD_4    = 8'hF0;

    // Code point limits
    localparam logic [20:0] CP_MIN_2    = 21'h000080;
    localparam logic [20:0] CP_MIN_3    = 21'h000800;
    localparam logic [20:0] CP_MIN_4    = 21'h010000;
    localparam logic [20:0] CP_BMP_MAX  = 21'h00FFFF;
    localparam logic [20:0] CP_SURR_LO  = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI  = 21'h00DFFF;

    // Sequence classes (sequence length minus one)
    localparam logic [1:0] CLASS_2 = 2'd1;
    localparam logic [1:0] CLASS_3 = 2'd2;
    localparam logic [1:0] CLASS_4 = 2'd3;

    // One classified byte: optional leading '?', optional main character
    typedef struct packed {
        logic        repl;
        logic        has_main;
        logic [15:0] main_unit;
    } t_cmd;

    // A queue slot as seen on either side of the queue
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_slot;

endpackage

// ===== design/u8u2_front.sv =====
`timescale 1ns / 1ps

module u8u2_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte_in,
    output u8u2_pkg::t_slot   o_wr
);

    logic [20:0] r_partial;
    logic [1:0]  r_pending;
    logic [1:0]  r_class;
    logic [20:0] n_partial;
    logic [1:0]  n_pending;
    logic [1:0]  n_class;

    logic        is_cont;
    logic        is_lead;
    logic [20:0] cp_next;
    logic [20:0] cp_min;
    logic        cp_ok;
    u8u2_pkg::t_cmd cmd;

    assign is_cont = (i_byte_in & u8u2_pkg::BYTE_CONT_MASK) == u8u2_pkg::BYTE_CONT_TAG;
    assign is_lead = (i_byte_in >= u8u2_pkg::BYTE_LEAD_LO)
                  && (i_byte_in <= u8u2_pkg::BYTE_LEAD_HI);
    assign cp_next = {r_partial[14:0], i_byte_in[5:0]};

    // Pick the smallest legal code point for the open sequence
    always_comb begin
        unique case (r_class)
            u8u2_pkg::CLASS_4: cp_min = u8u2_pkg::CP_MIN_4;
            u8u2_pkg::CLASS_3: cp_min = u8u2_pkg::CP_MIN_3;
            default:           cp_min = u8u2_pkg::CP_MIN_2;
        endcase
    end

    // Accept only code points the console can show: BMP, not overlong, no surrogates
    assign cp_ok = (cp_next >= cp_min) && (cp_next <= u8u2_pkg::CP_BMP_MAX)
                && !((cp_next >= u8u2_pkg::CP_SURR_LO) && (cp_next <= u8u2_pkg::CP_SURR_HI));

    // Classify the byte and compute the next decode state
    always_comb begin
        n_partial     = r_partial;
        n_pending     = r_pending;
        n_class       = r_class;
        cmd.repl      = 1'b0;
        cmd.has_main  = 1'b0;
        cmd.main_unit = u8u2_pkg::UNIT_REPL;
        if (r_pending != 2'd0 && is_cont) begin
            n_partial = cp_next;
            n_pending = r_pending - 2'd1;
            if (r_pending == 2'd1) begin
                cmd.has_main  = 1'b1;
                cmd.main_unit = cp_ok ? cp_next[15:0] : u8u2_pkg::UNIT_REPL;
            end
        end else begin
            // Drop an interrupted sequence, then handle the byte afresh
            cmd.repl  = (r_pending != 2'd0);
            n_pending = 2'd0;
            if (!i_byte_in[7]) begin
                cmd.has_main  = 1'b1;
                cmd.main_unit = {8'h00, i_byte_in};
            end else if (is_lead) begin
                if (i_byte_in >= u8u2_pkg::BYTE_LEAD_4) begin
                    n_pending = u8u2_pkg::CLASS_4;
                    n_class   = u8u2_pkg::CLASS_4;
                    n_partial = {18'd0, i_byte_in[2:0]};
                end else if (i_byte_in >= u8u2_pkg::BYTE_LEAD_3) begin
                    n_pending = u8u2_pkg::CLASS_3;
                    n_class   = u8u2_pkg::CLASS_3;
                    n_partial = {17'd0, i_byte_in[3:0]};
                end else begin
                    n_pending = u8u2_pkg::CLASS_2;
                    n_class   = u8u2_pkg::CLASS_2;
                    n_partial = {16'd0, i_byte_in[4:0]};
                end
            end else begin
                cmd.has_main  = 1'b1;
                cmd.main_unit = u8u2_pkg::UNIT_REPL;
            end
        end
    end

    // Enqueue only bytes that produce at least one unit
    assign o_wr.valid = i_accept && (cmd.repl || cmd.has_main);
    assign o_wr.cmd   = cmd;

    // Advance decode state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_pending <= '0;
            r_class   <= '0;
        end else if (i_accept) begin
            r_partial <= n_partial;
            r_pending <= n_pending;
            r_class   <= n_class;
        end
    end

endmodule

// ===== design/u8u2_queue.sv =====
`timescale 1ns / 1ps

module u8u2_queue #(
    parameter int DEPTH = u8u2_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  u8u2_pkg::t_slot i_wr,
    output logic            o_full,
    output u8u2_pkg::t_slot o_head,
    input  logic            i_deq
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    u8u2_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_wr;
    logic           do_rd;

    assign o_full       = (r_count == CW'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];
    assign do_wr        = i_wr.valid && !o_full;
    assign do_rd        = i_deq && o_head.valid;

    // Store incoming commands
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr.cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/u8u2_back.sv =====
`timescale 1ns / 1ps

module u8u2_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  u8u2_pkg::t_slot i_head,
    output logic            o_deq,
    output logic            o_empty,
    input  logic            i_pop,
    output logic [15:0]     o_code_unit,
    output logic            o_last_unit
);

    logic        r_out_valid;
    logic [15:0] r_code_unit;
    logic        r_last_unit;
    logic [1:0]  r_idx;
    logic [1:0]  n_idx;

    logic [15:0] units [3];
    logic [1:0]  cnt;
    logic        is_lf;
    logic        load;
    logic        last;

    assign is_lf = i_head.cmd.main_unit == u8u2_pkg::UNIT_LF;

    // Lay out the units of the head command: '?', then the character, with CR before LF
    always_comb begin
        units[0] = u8u2_pkg::UNIT_REPL;
        units[1] = u8u2_pkg::UNIT_REPL;
        units[2] = u8u2_pkg::UNIT_REPL;
        cnt      = 2'd0;
        if (i_head.cmd.repl) begin
            cnt = 2'd1;
        end
        if (i_head.cmd.has_main) begin
            if (is_lf) begin
                units[cnt]        = u8u2_pkg::UNIT_CR;
                units[cnt + 2'd1] = u8u2_pkg::UNIT_LF;
                cnt               = cnt + 2'd2;
            end else begin
                units[cnt] = i_head.cmd.main_unit;
                cnt        = cnt + 2'd1;
            end
        end
    end

    assign load  = i_head.valid && (!r_out_valid || i_pop);
    assign last  = (r_idx == cnt - 2'd1);
    assign o_deq = load && last;
    assign n_idx = o_deq ? 2'd0 : r_idx + 2'd1;

    // Sequence units into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 2'd0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= n_idx;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold payload until popped
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_code_unit <= units[r_idx];
            r_last_unit <= last;
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_code_unit = r_code_unit;
    assign o_last_unit = r_last_unit;

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head.valid |-> (r_idx < cnt))
        else $error("unit index beyond command length");

    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_head.valid |-> (r_idx == 2'd0))
        else $error("unit index not cleared with queue empty");

    a_deq_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_deq |=> (r_out_valid && r_last_unit))
        else $error("command retired without a last unit");
`endif

endmodule

// ===== design/utf8_to_ucs2_console_decoder_core.sv =====
`timescale 1ns / 1ps

// Path: a byte accepted goes to the command queue, then each unit to the output register.
// Throughput: one byte per cycle while full is low; a byte giving two or three units holds the
//   output per unit; the queue (QUEUE_DEPTH entries) absorbs it, full rises only when it fills.
// A lead byte alone produces no unit and takes no queue entry.
// Reset: synchronous, active low; clears decode state, queue and output register.

module utf8_to_ucs2_console_decoder_core #(
    parameter int QUEUE_DEPTH = u8u2_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_byte_in,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_code_unit,
    output logic        o_last_unit
);

    u8u2_pkg::t_slot wr;
    u8u2_pkg::t_slot head;
    logic            deq;
    logic            accept;

    assign accept = push && !full;

    u8u2_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_byte_in (i_byte_in),
        .o_wr      (wr)
    );

    u8u2_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .o_full  (full),
        .o_head  (head),
        .i_deq   (deq)
    );

    u8u2_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_deq       (deq),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_code_unit (o_code_unit),
        .o_last_unit (o_last_unit)
    );

endmodule

// ===== tb/ucs2_unit_checker.sv =====
`timescale 1ns / 1ps

module ucs2_unit_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  i_byte_in,
    input  logic        empty,
    input  logic        pop,
    input  logic [15:0] o_code_unit,
    input  logic        o_last_unit,
    output int          o_fail_count,
    output int          o_units_waiting,
    output int          o_bytes_taken,
    output int          o_units_taken,
    output int          o_repl_units
);

    localparam logic [20:0] CP_MAX = 21'h10FFFF;

    typedef struct packed {
        logic [15:0] unit;
        logic        last;
    } t_unit_rec;

    // Decoder state mirrored from the byte stream
    logic [20:0] cp_accum;
    logic [1:0]  cont_left;
    logic [1:0]  seq_class;

    t_unit_rec   expected_units[$];
    logic [15:0] byte_units[$];
    t_unit_rec   oldest;

    initial begin
        o_fail_count    = 0;
        o_units_waiting = 0;
        o_bytes_taken   = 0;
        o_units_taken   = 0;
        o_repl_units    = 0;
        cp_accum        = '0;
        cont_left       = '0;
        seq_class       = '0;
    end

    function automatic logic [20:0] class_floor(input logic [1:0] cls);
        case (cls)
            u8u2_pkg::CLASS_4: return u8u2_pkg::CP_MIN_4;
            u8u2_pkg::CLASS_3: return u8u2_pkg::CP_MIN_3;
            default:           return u8u2_pkg::CP_MIN_2;
        endcase
    endfunction

    // One console character: newline becomes CR LF, anything outside the BMP or a surrogate is '?'
    task automatic add_char(input logic [20:0] c);
        if (c == {13'd0, u8u2_pkg::UNIT_LF[7:0]})
            byte_units.push_back(u8u2_pkg::UNIT_CR);
        if (c > u8u2_pkg::CP_BMP_MAX
            || (c >= u8u2_pkg::CP_SURR_LO && c <= u8u2_pkg::CP_SURR_HI))
            byte_units.push_back(u8u2_pkg::UNIT_REPL);
        else
            byte_units.push_back(c[15:0]);
    endtask

    // Work out the code units one input byte causes and queue them
    task automatic decode_byte(input logic [7:0] b);
        logic [20:0] cp;
        logic [1:0]  len;
        t_unit_rec   rec;
        byte_units.delete();
        if (cont_left != 2'd0 && (b & u8u2_pkg::BYTE_CONT_MASK) == u8u2_pkg::BYTE_CONT_TAG) begin
            cp_accum  = {cp_accum[14:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
                cp = cp_accum;
                if (cp < class_floor(seq_class) || cp > CP_MAX)
                    cp = {5'd0, u8u2_pkg::UNIT_REPL};
                add_char(cp);
            end
        end else begin
            // Drop an interrupted sequence, then take the byte afresh
            if (cont_left != 2'd0) begin
                cont_left = 2'd0;
                add_char({5'd0, u8u2_pkg::UNIT_REPL});
            end
            if (b < u8u2_pkg::BYTE_CONT_TAG) begin
                add_char({13'd0, b});
            end else if (b >= u8u2_pkg::BYTE_LEAD_LO && b <= u8u2_pkg::BYTE_LEAD_HI) begin
                len = (b >= u8u2_pkg::BYTE_LEAD_4) ? u8u2_pkg::CLASS_4
                    : ((b >= u8u2_pkg::BYTE_LEAD_3) ? u8u2_pkg::CLASS_3 : u8u2_pkg::CLASS_2);
                cont_left = len;
                seq_class = len;
                case (len)
                    u8u2_pkg::CLASS_2: cp_accum = {16'd0, b[4:0]};
                    u8u2_pkg::CLASS_3: cp_accum = {17'd0, b[3:0]};
                    default:           cp_accum = {18'd0, b[2:0]};
                endcase
            end else begin
                add_char({5'd0, u8u2_pkg::UNIT_REPL});
            end
        end
        foreach (byte_units[i]) begin
            rec.unit = byte_units[i];
            rec.last = (i == byte_units.size() - 1);
            expected_units.push_back(rec);
        end
    endtask

    // Compare each popped unit with the oldest expectation, then predict from the pushed byte
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_units.delete();
            cp_accum  = '0;
            cont_left = '0;
            seq_class = '0;
        end else begin
            if (pop && !empty) begin
                if (expected_units.size() == 0) begin
                    $error("unexpected transaction: code_unit %h last_unit %b",
                           o_code_unit, o_last_unit);
                    o_fail_count++;
                end else begin
                    oldest = expected_units.pop_front();
                    if (o_code_unit !== oldest.unit) begin
                        $error("code_unit: expected %h, got %h", oldest.unit, o_code_unit);
                        o_fail_count++;
                    end
                    if (o_last_unit !== oldest.last) begin
                        $error("last_unit: expected %b, got %b", oldest.last, o_last_unit);
                        o_fail_count++;
                    end
                    o_units_taken++;
                    if (oldest.unit == u8u2_pkg::UNIT_REPL)
                        o_repl_units++;
                end
            end
            if (push && !full) begin
                decode_byte(i_byte_in);
                o_bytes_taken++;
            end
        end
        o_units_waiting = expected_units.size();
    end

endmodule

// ===== tb/tb_utf8_to_ucs2_console_decoder_core.sv =====
`timescale 1ns / 1ps

module tb_utf8_to_ucs2_console_decoder_core;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_byte_in;
    logic        empty;
    logic        pop;
    logic [15:0] o_code_unit;
    logic        o_last_unit;

    int fail_count;
    int units_waiting;
    int bytes_taken;
    int units_taken;
    int repl_units;

    // Idle control for the producer and the consumer process, and the count of full stalls
    bit tx_gaps = 1'b1;
    bit rx_gaps = 1'b1;
    int rx_hold = 0;
    int full_stalls = 0;

    // Edge cases: extremes, newline, shortest and longest legal forms, each kind of rejection
    logic [7:0] edge_bytes [25] = '{
        8'h00, 8'h7F, 8'h0A,
        8'hC2, 8'h80,
        8'hE0, 8'h80, 8'h80,
        8'hED, 8'hA0, 8'h80,
        8'hF0, 8'h90, 8'h80, 8'h80,
        8'hF4, 8'h90, 8'h80, 8'h80,
        8'h80, 8'hC0, 8'hC1, 8'hFF,
        8'hC2, 8'h0A
    };

    utf8_to_ucs2_console_decoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_byte_in   (i_byte_in),
        .empty       (empty),
        .pop         (pop),
        .o_code_unit (o_code_unit),
        .o_last_unit (o_last_unit)
    );

    ucs2_unit_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_byte_in       (i_byte_in),
        .empty           (empty),
        .pop             (pop),
        .o_code_unit     (o_code_unit),
        .o_last_unit     (o_last_unit),
        .o_fail_count    (fail_count),
        .o_units_waiting (units_waiting),
        .o_bytes_taken   (bytes_taken),
        .o_units_taken   (units_taken),
        .o_repl_units    (repl_units)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // Offer one byte and hold it until the transaction completes
    task automatic send_byte(input logic [7:0] b);
        int gap;
        push      <= 1'b1;
        i_byte_in <= b;
        @(posedge i_clk);
        while (full) begin
            full_stalls++;
            @(posedge i_clk);
        end
        gap = tx_gaps ? rand_gap() : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every predicted unit has been popped
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (units_waiting != 0) @(posedge i_clk);
    endtask

    // One character of random content: mostly well formed, some noise and broken sequences
    task automatic send_random_char();
        int kind;
        int n_cont;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2: begin
                if ($urandom_range(0, 7) == 0)
                    send_byte(8'h0A);
                else
                    send_byte(8'($urandom_range(0, 127)));
            end
            3, 4: begin
                send_byte(8'($urandom_range(8'hC2, 8'hDF)));
                send_byte(cont_byte());
            end
            5, 6: begin
                send_byte(8'($urandom_range(8'hE0, 8'hEF)));
                repeat (2) send_byte(cont_byte());
            end
            7: begin
                send_byte(8'($urandom_range(8'hF0, 8'hF4)));
                repeat (3) send_byte(cont_byte());
            end
            8: begin
                send_byte(8'($urandom_range(0, 255)));
            end
            default: begin
                // Often truncate a sequence, then follow it with any byte
                n_cont = $urandom_range(0, 2);
                send_byte(8'($urandom_range(8'hC2, 8'hF4)));
                repeat (n_cont) send_byte(cont_byte());
                send_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // Consumer: pop with random stalls, or hold off entirely while rx_hold runs down
    initial begin
        int stall;
        stall = 0;
        pop <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                rx_hold--;
                pop <= 1'b0;
            end else begin
                if (pop && !empty && rx_gaps)
                    stall = rand_gap();
                if (stall > 0) begin
                    stall--;
                    pop <= 1'b0;
                end else begin
                    pop <= 1'b1;
                end
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int start_bytes;
        i_rst_n   <= 1'b0;
        push      <= 1'b0;
        i_byte_in <= 8'h00;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (edge_bytes[i]) send_byte(edge_bytes[i]);
        wait_drained();

        // Back to back on both sides
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        start_bytes = bytes_taken;
        while (bytes_taken - start_bytes < 40) send_random_char();
        wait_drained();

        // Freeze the consumer while newlines pile up until intake stalls
        tx_gaps = 1'b0;
        rx_hold = 300;
        repeat (16) send_byte(8'h0A);
        wait_drained();

        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        start_bytes = bytes_taken;
        while (bytes_taken - start_bytes < 70) send_random_char();
        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("Run covered %0d bytes in, %0d code units out (%0d replacement units).",
                 bytes_taken, units_taken, repl_units);
        $display("Intake stalled on full for %0d cycles; mismatches: %0d.",
                 full_stalls, fail_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
